// ----- rtl/core/u16nl_pkg.sv -----
// Package for the UTF-16 newline converter: character codes, byte order and
// line-ending codes, register indexes and the command passed from front to back.
// No dependencies.
package u16nl_pkg;

	localparam logic [7:0] BOM_LE   = 8'hFF;
	localparam logic [7:0] BOM_BE   = 8'hFE;
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	localparam logic [1:0] FMT_UNIX = 2'd0;
	localparam logic [1:0] FMT_MAC  = 2'd1;
	localparam logic [1:0] FMT_DOS  = 2'd2;

	localparam logic [1:0] REG_IN_FORMAT  = 2'd0;
	localparam logic [1:0] REG_OUT_FORMAT = 2'd1;
	localparam logic [1:0] REG_SWAP_BYTES = 2'd2;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		ORDER_NONE = 2'd0,
		ORDER_LE   = 2'd1,
		ORDER_BE   = 2'd2
	} order_t;

	typedef struct packed {
		logic [7:0] unit0_first;
		logic [7:0] unit0_second;
		logic [7:0] unit1_first;
		logic [7:0] unit1_second;
		logic       two;
	} cmd_t;

endpackage

// ----- rtl/core/u16nl_in_if.sv -----
// Request channel carrying one UTF-16 code unit as two stream bytes.
// No dependencies.
interface u16nl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] first_byte;
	logic [7:0] second_byte;

	modport source(output valid, first_byte, second_byte, input ready);
	modport sink(input valid, first_byte, second_byte, output ready);
endinterface

// ----- rtl/core/u16nl_out_if.sv -----
// Request channel carrying one emitted UTF-16 code unit.
// No dependencies.
interface u16nl_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_first_byte;
	logic [7:0] out_second_byte;
	logic       last_of_run;

	modport source(output valid, out_first_byte, out_second_byte, last_of_run, input ready);
	modport sink(input valid, out_first_byte, out_second_byte, last_of_run, output ready);
endinterface

// ----- rtl/core/u16nl_front.sv -----
// Front end: holds the configuration and stream state, accepts code units and
// classifies each into a command of one or two output units, or none.
// Depends on u16nl_pkg.
module u16nl_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_idx,
	input  logic [1:0]       cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_first,
	input  logic [7:0]       in_second,
	input  logic             q_full,
	output logic             push,
	output u16nl_pkg::cmd_t  push_cmd
);

	logic [1:0]        in_format_q;
	logic [1:0]        out_format_q;
	logic              swap_q;
	logic              seen_q;
	u16nl_pkg::order_t order_q;
	logic              skip_q;

	logic              accept;
	u16nl_pkg::order_t order_now;
	logic              is_nl;
	logic              emit;
	logic              skip_d;
	logic [7:0]        cr_first, cr_second, lf_first, lf_second;
	u16nl_pkg::cmd_t   nl_cmd;
	u16nl_pkg::cmd_t   unit_cmd;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		if (seen_q) begin
			order_now = order_q;
		end else if (in_first == u16nl_pkg::BOM_LE) begin
			order_now = u16nl_pkg::ORDER_LE;
		end else if (in_first == u16nl_pkg::BOM_BE) begin
			order_now = u16nl_pkg::ORDER_BE;
		end else begin
			order_now = u16nl_pkg::ORDER_NONE;
		end
	end

	always_comb begin
		unique case (order_now)
			u16nl_pkg::ORDER_LE: begin
				is_nl = (in_second == u16nl_pkg::CHAR_NUL) &&
					(in_first == u16nl_pkg::CHAR_CR || in_first == u16nl_pkg::CHAR_LF);
			end
			u16nl_pkg::ORDER_BE: begin
				is_nl = (in_first == u16nl_pkg::CHAR_NUL) &&
					(in_second == u16nl_pkg::CHAR_CR || in_second == u16nl_pkg::CHAR_LF);
			end
			default: begin
				is_nl = 1'b0;
			end
		endcase
	end

	// Newline characters in source order, then exchanged when swapping.
	always_comb begin
		logic [7:0] cr_a, cr_b, lf_a, lf_b;
		if (order_now == u16nl_pkg::ORDER_LE) begin
			cr_a = u16nl_pkg::CHAR_CR;
			cr_b = u16nl_pkg::CHAR_NUL;
			lf_a = u16nl_pkg::CHAR_LF;
			lf_b = u16nl_pkg::CHAR_NUL;
		end else begin
			cr_a = u16nl_pkg::CHAR_NUL;
			cr_b = u16nl_pkg::CHAR_CR;
			lf_a = u16nl_pkg::CHAR_NUL;
			lf_b = u16nl_pkg::CHAR_LF;
		end
		cr_first  = swap_q ? cr_b : cr_a;
		cr_second = swap_q ? cr_a : cr_b;
		lf_first  = swap_q ? lf_b : lf_a;
		lf_second = swap_q ? lf_a : lf_b;
	end

	always_comb begin
		nl_cmd = '0;
		case (out_format_q)
			u16nl_pkg::FMT_DOS: begin
				nl_cmd.unit0_first  = cr_first;
				nl_cmd.unit0_second = cr_second;
				nl_cmd.unit1_first  = lf_first;
				nl_cmd.unit1_second = lf_second;
				nl_cmd.two          = 1'b1;
			end
			u16nl_pkg::FMT_MAC: begin
				nl_cmd.unit0_first  = cr_first;
				nl_cmd.unit0_second = cr_second;
			end
			default: begin
				nl_cmd.unit0_first  = lf_first;
				nl_cmd.unit0_second = lf_second;
			end
		endcase
	end

	always_comb begin
		unit_cmd              = '0;
		unit_cmd.unit0_first  = swap_q ? in_second : in_first;
		unit_cmd.unit0_second = swap_q ? in_first : in_second;
	end

	always_comb begin
		if (skip_q) begin
			emit     = 1'b1;
			skip_d   = 1'b0;
			push_cmd = nl_cmd;
		end else if (is_nl && in_format_q == u16nl_pkg::FMT_DOS) begin
			emit     = 1'b0;
			skip_d   = 1'b1;
			push_cmd = nl_cmd;
		end else if (is_nl) begin
			emit     = 1'b1;
			skip_d   = 1'b0;
			push_cmd = nl_cmd;
		end else begin
			emit     = 1'b1;
			skip_d   = 1'b0;
			push_cmd = unit_cmd;
		end
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_format_q  <= u16nl_pkg::FMT_UNIX;
			out_format_q <= u16nl_pkg::FMT_UNIX;
			swap_q       <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				u16nl_pkg::REG_IN_FORMAT:  in_format_q  <= cfg_data;
				u16nl_pkg::REG_OUT_FORMAT: out_format_q <= cfg_data;
				u16nl_pkg::REG_SWAP_BYTES: swap_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= 1'b0;
			order_q <= u16nl_pkg::ORDER_NONE;
			skip_q  <= 1'b0;
		end else if (accept) begin
			seen_q  <= 1'b1;
			order_q <= order_now;
			skip_q  <= skip_d;
		end
	end

	// A pending dropped unit only ever follows a newline of a marked stream.
	assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> (seen_q && order_q != u16nl_pkg::ORDER_NONE))
		else $error("skip pending in an unmarked stream");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && skip_q) |=> !skip_q)
		else $error("skip pending survived the dropped unit");

endmodule

// ----- rtl/core/u16nl_queue.sv -----
// Short command queue between the front and back ends, held in flip-flops.
// Depends on u16nl_pkg.
module u16nl_queue #(
	parameter int DEPTH = u16nl_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  u16nl_pkg::cmd_t push_cmd,
	output logic            full,
	output logic            q_valid,
	output u16nl_pkg::cmd_t q_cmd,
	input  logic            pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	u16nl_pkg::cmd_t entries_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_cmd   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("command pushed into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> q_valid)
		else $error("command popped from an empty queue");

endmodule

// ----- rtl/core/u16nl_back.sv -----
// Back end: expands each queued command into one or two output units and
// holds the current unit in an output register. Depends on u16nl_pkg.
module u16nl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  u16nl_pkg::cmd_t q_cmd,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_first,
	output logic [7:0]      out_second,
	output logic            out_last
);

	logic       valid_q;
	logic       phase_q;
	logic       load;
	logic [7:0] first_q, second_q;
	logic       last_q;

	assign load      = !valid_q || out_ready;
	assign pop       = load && q_valid && (phase_q || !q_cmd.two);
	assign out_valid = valid_q;
	assign out_first = first_q;
	assign out_second = second_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= q_valid;
			if (q_valid) begin
				phase_q <= !phase_q && q_cmd.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && q_valid) begin
			first_q  <= phase_q ? q_cmd.unit1_first : q_cmd.unit0_first;
			second_q <= phase_q ? q_cmd.unit1_second : q_cmd.unit0_second;
			last_q   <= phase_q || !q_cmd.two;
		end
	end

	// The second unit is only ever owed for a two-unit command still at the head.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (q_valid && q_cmd.two))
		else $error("second unit owed without a two-unit command");

	assert property (@(posedge clk) disable iff (!arst_n)
		(load && q_valid && q_cmd.two && !phase_q) |=> (phase_q && valid_q && !last_q))
		else $error("first unit of a pair not followed by its partner");

endmodule

// ----- rtl/core/utf16_newline_converter.sv -----
// UTF-16 newline converter: accepts one code unit per cycle while the queue is
// not full; a result unit passes through the queue and the output register after
// its request is accepted (for a DOS input newline, after the unit dropped after
// it). Sustained rate is one unit per cycle while the output is ready; a CR LF
// newline (two output units) with requests every cycle holds the input off.
// Reset clears the configuration to zero, the byte order detection and the queue.
module utf16_newline_converter #(
	parameter int QUEUE_DEPTH = u16nl_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [1:0]  cfg_data,
	u16nl_in_if.sink    in_ch,
	u16nl_out_if.source out_ch
);

	logic            q_full;
	logic            push;
	u16nl_pkg::cmd_t push_cmd;
	logic            q_valid;
	u16nl_pkg::cmd_t q_cmd;
	logic            pop;

	u16nl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_first  (in_ch.first_byte),
		.in_second (in_ch.second_byte),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	u16nl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.pop      (pop)
	);

	u16nl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_cmd      (q_cmd),
		.pop        (pop),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_first  (out_ch.out_first_byte),
		.out_second (out_ch.out_second_byte),
		.out_last   (out_ch.last_of_run)
	);

endmodule
